### src/hfcm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hfcm_pkg: shared types, constants and color table builders
// Register map, raster flag bundle and the elaboration-time builder of the
// height-to-color tables used by the false color mapper.
// ============================================================================
package hfcm_pkg;

   localparam int CFG_EXTENT_W = 13;
   localparam int CFG_BORDER_W = 12;
   localparam int CFG_DATA_W   = 13;
   localparam int CFG_INDEX_W  = 2;
   localparam int HEIGHT_W     = 8;
   localparam int CHANNEL_W    = 8;
   localparam int PIXEL_W      = 3 * CHANNEL_W;

   localparam logic [CFG_EXTENT_W-1:0] MAP_WIDTH_RESET   = 13'd256;
   localparam logic [CFG_EXTENT_W-1:0] MAP_HEIGHT_RESET  = 13'd256;
   localparam logic [CFG_BORDER_W-1:0] BORDER_SIZE_RESET = 12'd0;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CSR_MAP_WIDTH   = 2'd0,
      CSR_MAP_HEIGHT  = 2'd1,
      CSR_BORDER_SIZE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic in_border;
      logic frame_last;
   } pos_flags_type;

   typedef logic [255:0][PIXEL_W-1:0] color_table_type;

   // truncate, scale/offset for the border, saturate
   function automatic logic [CHANNEL_W-1:0] finish_channel(input longint c,
                                                           input logic border,
                                                           input longint off,
                                                           input longint k,
                                                           input longint c035,
                                                           input int unsigned frac);
      longint cc;
      longint v;
      cc = (c < 0) ? 64'sd0 : c;
      if (border) begin
         v = (cc * c035 + off * k * k) >>> (2 * frac);
      end else begin
         v = cc >>> frac;
      end
      if (v > 255) begin
         v = 255;
      end
      return v[CHANNEL_W-1:0];
   endfunction

   function automatic logic [PIXEL_W-1:0] ramp_pixel(input int unsigned z,
                                                     input logic border,
                                                     input int unsigned frac);
      longint k;
      longint t;
      longint lo;
      longint inv;
      longint d;
      longint u;
      longint r;
      longint g;
      longint b;
      longint c035;
      k    = 64'sd1 << frac;
      c035 = (35 * k + 50) / 100;
      t    = longint'(z) * ((k + 127) / 255);
      if (z < 39) begin
         lo  = 0;
         inv = (100 * k + 7) / 15;
      end else if (z < 115) begin
         lo  = (15 * k + 50) / 100;
         inv = (100 * k + 15) / 30;
      end else if (z < 192) begin
         lo  = (45 * k + 50) / 100;
         inv = (100 * k + 15) / 30;
      end else begin
         lo  = (75 * k + 50) / 100;
         inv = 4 * k;
      end
      d = t - lo;
      if (d < 0) begin
         d = 0;
      end
      u = (d * inv) >>> frac;
      if (z < 39) begin
         r = 25 * k + 35 * u;
         g = 70 * k + 90 * u;
         b = 55 * k + 40 * u;
      end else if (z < 115) begin
         r = 60 * k + 90 * u;
         g = 160 * k - 40 * u;
         b = 95 * k - 55 * u;
      end else if (z < 192) begin
         r = 150 * k + 60 * u;
         g = 120 * k + 40 * u;
         b = 40 * k + 30 * u;
      end else begin
         r = 210 * k + 45 * u;
         g = 160 * k + 95 * u;
         b = 70 * k + 185 * u;
      end
      return {finish_channel(b, border, 20, k, c035, frac),
              finish_channel(g, border, 20, k, c035, frac),
              finish_channel(r, border, 90, k, c035, frac)};
   endfunction

   function automatic color_table_type build_color_table(input logic border,
                                                         input int unsigned frac);
      color_table_type tbl;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = ramp_pixel(i, border, frac);
      end
      return tbl;
   endfunction

endpackage

### src/height_false_color_mapper.sv
`timescale 1ns / 1ps
// ============================================================================
// height_false_color_mapper: false color pixels from a height stream
// Height samples arrive in raster order on req_*; one RGB pixel per sample
// leaves on rsp_*, with tuser marking border cells and tlast the final cell
// of the frame.
//
// Usage:
//   - csr_we/csr_index/csr_wdata write map_width (0), map_height (1) and
//     border_size (2); write them while no request is in flight.
//   - One request per cycle sustained while the rsp side takes each pixel; a
//     request passes from the input register through the color table into
//     the result register, which drives its pixel on rsp_*.
//   - A stalled rsp side still lets one more request into the input
//     register; after that req_tready drops until the result register drains.
//   - Reset empties both registers, returns the raster position to the first
//     cell and loads 256 x 256 with no border.
// ============================================================================
module height_false_color_mapper
   import hfcm_pkg::*;
#(
   parameter int MAX_EXTENT    = 4096,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] height
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,  // [7:0] red, [15:8] green, [23:16] blue
   output logic                   rsp_tuser,  // [0] in_border
   output logic                   rsp_tlast
);

   logic [CFG_EXTENT_W-1:0] map_width_ff, map_width_in;
   logic [CFG_EXTENT_W-1:0] map_height_ff, map_height_in;
   logic [CFG_BORDER_W-1:0] border_size_ff, border_size_in;

   logic                    hold_valid_ff, hold_valid_in;
   logic [HEIGHT_W-1:0]     hold_height_ff, hold_height_in;
   pos_flags_type           hold_flags_ff, hold_flags_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]      rsp_pixel_ff, rsp_pixel_in;
   pos_flags_type           rsp_flags_ff, rsp_flags_in;

   logic                    req_accept;
   logic                    result_load;
   pos_flags_type           pos_flags;
   logic [PIXEL_W-1:0]      pixel;

   // configuration registers
   always_comb begin
      map_width_in   = map_width_ff;
      map_height_in  = map_height_ff;
      border_size_in = border_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:   map_width_in   = csr_wdata[CFG_EXTENT_W-1:0];
            CSR_MAP_HEIGHT:  map_height_in  = csr_wdata[CFG_EXTENT_W-1:0];
            CSR_BORDER_SIZE: border_size_in = csr_wdata[CFG_BORDER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= MAP_WIDTH_RESET;
         map_height_ff  <= MAP_HEIGHT_RESET;
         border_size_ff <= BORDER_SIZE_RESET;
      end else begin
         map_width_ff   <= map_width_in;
         map_height_ff  <= map_height_in;
         border_size_ff <= border_size_in;
      end
   end

   hfcm_raster #(
      .MAX_EXTENT (MAX_EXTENT)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_accept),
      .map_width   (map_width_ff),
      .map_height  (map_height_ff),
      .border_size (border_size_ff),
      .flags       (pos_flags)
   );

   hfcm_color #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_color (
      .height    (hold_height_ff),
      .in_border (hold_flags_ff.in_border),
      .pixel     (pixel)
   );

   // two-stage pipeline: input register, then result register
   always_comb begin
      result_load = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready  = !hold_valid_ff || result_load;
      req_accept  = req_tvalid && req_tready;

      hold_valid_in  = req_accept || (hold_valid_ff && !result_load);
      hold_height_in = req_accept ? req_tdata[HEIGHT_W-1:0] : hold_height_ff;
      hold_flags_in  = req_accept ? pos_flags : hold_flags_ff;

      rsp_valid_in = result_load || (rsp_valid_ff && !rsp_tready);
      rsp_pixel_in = result_load ? pixel : rsp_pixel_ff;
      rsp_flags_in = result_load ? hold_flags_ff : rsp_flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_height_ff <= hold_height_in;
      hold_flags_ff  <= hold_flags_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_flags_ff   <= rsp_flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_flags_ff.in_border;
   assign rsp_tlast  = rsp_flags_ff.frame_last;

   assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> req_tready)
      else $error("input register empty but request not taken");

   assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff && !result_load && !reset |=> hold_valid_ff && $stable(hold_height_ff))
      else $error("held request lost before reaching result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flags_ff.in_border |->
         (rsp_pixel_ff[7:0] >= 8'd90) && (rsp_pixel_ff[15:8] >= 8'd20)
         && (rsp_pixel_ff[23:16] >= 8'd20))
      else $error("border pixel below its color offset");

endmodule

### src/hfcm_raster.sv
`timescale 1ns / 1ps
// ============================================================================
// hfcm_raster: column/row tracking and border classification
// Holds the raster position of the next cell, flags border cells and the
// final cell of a frame, and advances on every accepted request.
// ============================================================================
module hfcm_raster
   import hfcm_pkg::*;
#(
   parameter int MAX_EXTENT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [CFG_EXTENT_W-1:0] map_width,
   input  logic [CFG_EXTENT_W-1:0] map_height,
   input  logic [CFG_BORDER_W-1:0] border_size,
   output pos_flags_type           flags
);

   localparam int CNT_W = $clog2(MAX_EXTENT);
   localparam int EXT_W = $clog2(MAX_EXTENT + 1);
   localparam int CMP_W = ((EXT_W > CFG_EXTENT_W) ? EXT_W : CFG_EXTENT_W) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_EXTENT);

   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CMP_W-1:0] width_ext, height_ext, eff_w, eff_h;
   logic [CMP_W-1:0] x_ext, y_ext, b_ext, x_next, y_next;
   logic             line_end, frame_end;

   always_comb begin
      width_ext  = CMP_W'(map_width);
      height_ext = CMP_W'(map_height);
      eff_w = (map_width == '0) ? CMP_W'(1) : ((width_ext > MAX_CMP) ? MAX_CMP : width_ext);
      eff_h = (map_height == '0) ? CMP_W'(1) : ((height_ext > MAX_CMP) ? MAX_CMP : height_ext);
      x_ext  = CMP_W'(col_ff);
      y_ext  = CMP_W'(row_ff);
      b_ext  = CMP_W'(border_size);
      x_next = x_ext + CMP_W'(1);
      y_next = y_ext + CMP_W'(1);
      line_end  = (x_next >= eff_w);
      frame_end = line_end && (y_next >= eff_h);
      flags.in_border  = (x_ext < b_ext) || (y_ext < b_ext)
                         || (x_ext + b_ext >= eff_w) || (y_ext + b_ext >= eff_h);
      flags.frame_last = frame_end;
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (line_end) begin
            col_in = '0;
            row_in = (y_next >= eff_h) ? '0 : CNT_W'(y_next);
         end else begin
            col_in = CNT_W'(x_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### src/hfcm_color.sv
`timescale 1ns / 1ps
// ============================================================================
// hfcm_color: height to false color lookup
// Maps one height sample through the four-segment color ramp, with the
// border scale and offset folded into a second table.
// ============================================================================
module hfcm_color
   import hfcm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic [HEIGHT_W-1:0] height,
   input  logic                in_border,
   output logic [PIXEL_W-1:0]  pixel
);

   localparam color_table_type PLAIN_TBL  = build_color_table(1'b0, FRACTION_BITS);
   localparam color_table_type BORDER_TBL = build_color_table(1'b1, FRACTION_BITS);

   assign pixel = in_border ? BORDER_TBL[height] : PLAIN_TBL[height];

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for height_false_color_mapper
// Drives height requests in raster order under several frame sizes and
// border widths, predicts every false color pixel with a fixed point model
// of the color ramp and the raster position, and checks each pixel as it
// leaves, under random request bursts and response stalls.
// ============================================================================
module testbench;
   import hfcm_pkg::*;

   localparam int          FRAC        = 16;
   localparam int unsigned EXTENT_MAX  = 4096;
   localparam longint      ONE         = 64'sd1 << FRAC;
   localparam longint      STEP_255    = (ONE + 127) / 255;
   localparam longint      LO_015      = (15 * ONE + 50) / 100;
   localparam longint      LO_045      = (45 * ONE + 50) / 100;
   localparam longint      LO_075      = (75 * ONE + 50) / 100;
   localparam longint      INV_015     = (100 * ONE + 7) / 15;
   localparam longint      INV_030     = (100 * ONE + 15) / 30;
   localparam longint      INV_025     = 4 * ONE;
   localparam longint      SCALE_035   = (35 * ONE + 50) / 100;
   localparam longint      CYCLE_LIMIT = 1000000;
   localparam int          MAX_REPORTS = 10;

   localparam logic [CFG_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [7:0][7:0] KNEES = {8'd255, 8'd192, 8'd191, 8'd115,
                                        8'd114, 8'd39, 8'd38, 8'd0};

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       in_border;
      logic       frame_last;
   } pixel_rec_type;

   class pixel_scoreboard;
      int unsigned   map_w;
      int unsigned   map_h;
      int unsigned   band_w;
      int unsigned   col;
      int unsigned   row;
      pixel_rec_type expected[$];
      int            errors;

      function new();
         map_w  = MAP_WIDTH_RESET;
         map_h  = MAP_HEIGHT_RESET;
         band_w = BORDER_SIZE_RESET;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
         case (idx)
            CSR_MAP_WIDTH:   map_w = v;
            CSR_MAP_HEIGHT:  map_h = v;
            CSR_BORDER_SIZE: band_w = v & 13'h0FFF;
            default: ;
         endcase
      endfunction

      function longint slope_pos(longint t, longint lo, longint inv);
         longint d;
         d = t - lo;
         if (d < 0) d = 0;
         return (d * inv) >>> FRAC;
      endfunction

      function logic [7:0] channel(longint c, bit band, longint off);
         longint v;
         if (c < 0) c = 0;
         if (band) v = (c * SCALE_035 + off * ONE * ONE) >>> (2 * FRAC);
         else v = c >>> FRAC;
         if (v > 255) v = 255;
         return v[7:0];
      endfunction

      function void note_height(logic [7:0] z);
         int unsigned   w;
         int unsigned   h;
         longint        t;
         longint        u;
         longint        r;
         longint        g;
         longint        b;
         bit            band;
         bit            line_end;
         pixel_rec_type px;
         w = (map_w == 0) ? 1 : ((map_w > EXTENT_MAX) ? EXTENT_MAX : map_w);
         h = (map_h == 0) ? 1 : ((map_h > EXTENT_MAX) ? EXTENT_MAX : map_h);
         band = (col < band_w) || (row < band_w) || (col + band_w >= w) ||
                (row + band_w >= h);
         t = longint'(z) * STEP_255;
         if (z < 39) begin
            u = slope_pos(t, 0, INV_015);
            r = 25 * ONE + 35 * u;
            g = 70 * ONE + 90 * u;
            b = 55 * ONE + 40 * u;
         end else if (z < 115) begin
            u = slope_pos(t, LO_015, INV_030);
            r = 60 * ONE + 90 * u;
            g = 160 * ONE - 40 * u;
            b = 95 * ONE - 55 * u;
         end else if (z < 192) begin
            u = slope_pos(t, LO_045, INV_030);
            r = 150 * ONE + 60 * u;
            g = 120 * ONE + 40 * u;
            b = 40 * ONE + 30 * u;
         end else begin
            u = slope_pos(t, LO_075, INV_025);
            r = 210 * ONE + 45 * u;
            g = 160 * ONE + 95 * u;
            b = 70 * ONE + 185 * u;
         end
         line_end = (col + 1 >= w);
         px.red        = channel(r, band, 90);
         px.green      = channel(g, band, 20);
         px.blue       = channel(b, band, 20);
         px.in_border  = band;
         px.frame_last = line_end && (row + 1 >= h);
         expected.push_back(px);
         if (line_end) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic band, logic last);
         pixel_rec_type want;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected pixel r=%0d g=%0d b=%0d border=%b last=%b",
                        r, g, b, band, last);
            return;
         end
         want = expected.pop_front();
         if (want.red !== r || want.green !== g || want.blue !== b ||
             want.in_border !== band || want.frame_last !== last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("pixel mismatch: expected r=%0d g=%0d b=%0d border=%b last=%b",
                        want.red, want.green, want.blue, want.in_border,
                        want.frame_last);
               $display("                got      r=%0d g=%0d b=%0d border=%b last=%b",
                        r, g, b, band, last);
            end
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CFG_INDEX_W-1:0] csr_index  = CSR_MAP_WIDTH;
   logic [CFG_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;  // [7:0] height
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;  // [7:0] red, [15:8] green, [23:16] blue
   logic                   rsp_tuser;  // [0] in_border
   logic                   rsp_tlast;

   pixel_scoreboard sb;
   longint          cycle_count = 0;
   int              burst_left  = 0;
   bit              gaps_on     = 1'b1;
   int              stall_mode  = 0;
   int              stall_left  = 0;

   height_false_color_mapper u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[height_false_color_mapper] ERROR");
         $finish;
      end
   end

   // response side: check accepted pixels, stall on a changing pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check_pixel(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                        rsp_tuser, rsp_tlast);
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 4);
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0, 1:    rsp_tready <= 1'b1;
         2:       rsp_tready <= ($urandom_range(0, 3) != 0);
         3:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ~rsp_tready;
      endcase
   end

   function automatic logic [7:0] pick_height();
      case ($urandom_range(0, 3))
         0:       return KNEES[$urandom_range(0, 7)];
         1:       return KNEES[$urandom_range(0, 7)] + 8'($urandom_range(0, 2)) - 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic csr_write(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic program_map(input int unsigned w, input int unsigned h,
                              input int unsigned b);
      csr_write(CSR_MAP_WIDTH, CFG_DATA_W'(w));
      csr_write(CSR_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
      csr_write(CSR_MAP_HEIGHT, CFG_DATA_W'(h));
      csr_write(CSR_BORDER_SIZE, CFG_DATA_W'(b));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_height(input logic [7:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= z;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_height(z);
   endtask

   // drop valid, drain every expected pixel, then let the pipeline settle
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h,
                            input int unsigned b, input int n, input bit gaps);
      gaps_on = gaps;
      program_map(w, h, b);
      repeat (n) send_height(pick_height());
      finish_phase();
   endtask

   initial begin
      logic [7:0] ramp_pts[15];
      logic [7:0] reset_pts[4];
      int         random_total;
      int         n;
      sb = new();
      reset_pts = '{8'd0, 8'd255, 8'd38, 8'd39};
      ramp_pts  = '{8'd0, 8'd1, 8'd38, 8'd39, 8'd40, 8'd114, 8'd115, 8'd116,
                    8'd191, 8'd192, 8'd193, 8'd254, 8'd255, 8'd127, 8'd64};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry first, then every ramp knee on a small bordered frame
      foreach (reset_pts[i]) send_height(reset_pts[i]);
      finish_phase();
      program_map(5, 3, 1);
      foreach (ramp_pts[i]) send_height(ramp_pts[i]);
      finish_phase();

      run_phase(0, 0, 0, 20, 1'b1);
      run_phase(0, 0, 1, 10, 1'b1);
      run_phase(6, 6, 3, 60, 1'b1);
      run_phase(4096, 4096, 2048, 60, 1'b1);
      run_phase(7, 5, 2, 23, 1'b1);
      run_phase(3, 2, 0, 30, 1'b1);
      run_phase(8191, 1, 0, 60, 1'b0);
      run_phase(1, 4097, 0, 60, 1'b0);
      run_phase(9, 7, 4095, 40, 1'b1);

      random_total = 0;
      while (random_total < 1600) begin
         n = $urandom_range(40, 160);
         run_phase(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 24),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 16),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(0, 4),
                   n, ($urandom_range(0, 3) != 0));
         random_total += n;
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[height_false_color_mapper] OK");
      else
         $display("[height_false_color_mapper] ERROR");
      $finish;
   end

endmodule

### sim.f
src/hfcm_pkg.sv
src/hfcm_raster.sv
src/hfcm_color.sv
src/height_false_color_mapper.sv
tb/sv/testbench.sv
